### rtl/stpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpc_pkg
// shared types, codes and layout helpers of the sms tpdu structure checker
// ----------------------------------------------------------------------------
package stpc_pkg;

	// status codes of a report
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_TOO_LONG    = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT   = 3'd2;
	localparam logic [2:0] ST_ADDR_TRUNC  = 3'd3;
	localparam logic [2:0] ST_NO_PID_DCS  = 3'd4;
	localparam logic [2:0] ST_NO_VP       = 3'd5;
	localparam logic [2:0] ST_NO_STAMP    = 3'd6;
	localparam logic [2:0] ST_UD_TRUNC    = 3'd7;

	// message type indicator codes
	localparam logic [1:0] MT_DELIVER = 2'd0;
	localparam logic [1:0] MT_SUBMIT  = 2'd1;
	localparam logic [1:0] MT_REPORT  = 2'd2;
	localparam logic [1:0] MT_COMMAND = 2'd3;

	// validity period format codes
	localparam logic [1:0] VPF_NONE     = 2'd0;
	localparam logic [1:0] VPF_RELATIVE = 2'd2;

	localparam logic [8:0] COUNT_MAX   = 9'd511;
	localparam logic [3:0] STAMP_BYTES = 4'd7;

	// register indexes
	localparam logic REG_MAX_LENGTH = 1'b0;

	localparam logic [7:0] MAX_LENGTH_RESET = 8'd164;

	// one tpdu as seen at its final byte
	typedef struct packed {
		logic [7:0] head;
		logic [7:0] digits;
		logic [7:0] dcs;
		logic [7:0] udl;
		logic [8:0] len;
	} frame_t;

	// byte position just past the address field
	function automatic logic [8:0] after_address(logic submit, logic [7:0] digits);
		logic [8:0] p;
		p = submit ? 9'd3 : 9'd2;
		if (digits != 8'd0)
			p = p + 9'd1 + (({1'b0, digits} + 9'd1) >> 1);
		return p;
	endfunction

	// size of the validity period (submit) or timestamp (deliver)
	function automatic logic [3:0] vp_bytes(logic submit, logic [7:0] head);
		logic [3:0] n;
		n = STAMP_BYTES;
		if (submit) begin
			if (head[4:3] == VPF_NONE)
				n = 4'd0;
			else if (head[4:3] == VPF_RELATIVE)
				n = 4'd1;
		end
		return n;
	endfunction

	// gsm 7-bit default alphabet per the dcs coding groups
	function automatic logic dcs_is_gsm7(logic [7:0] dcs);
		logic g;
		g = 1'b0;
		if (dcs[7:4] <= 4'h7)
			g = !dcs[5] && (dcs[3:2] == 2'b00);
		else if (dcs[7:4] == 4'hC || dcs[7:4] == 4'hD)
			g = 1'b1;
		else if (dcs[7:4] == 4'hF)
			g = !dcs[2];
		return g;
	endfunction

endpackage

### rtl/stpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpc_byte_if / stpc_result_if
// valid/ready channels for tpdu bytes and per-tpdu reports
// ----------------------------------------------------------------------------
interface stpc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface stpc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [1:0] message_type;
	logic [7:0] lead_byte;
	logic [8:0] total_length;

	modport source (output valid, output status, output message_type,
		output lead_byte, output total_length, input ready);
	modport sink (input valid, input status, input message_type,
		input lead_byte, input total_length, output ready);
endinterface

### rtl/stpc_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpc_frame
// byte counter and field captures of the tpdu in flight
// ----------------------------------------------------------------------------
module stpc_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               last,
	output stpc_pkg::frame_t   snap
);

	logic [8:0] count_q;
	logic [7:0] head_q;
	logic [7:0] digits_q;
	logic [7:0] dcs_q;
	logic [7:0] udl_q;

	logic [7:0] head_n;
	logic [7:0] digits_n;
	logic [7:0] dcs_n;
	logic [7:0] udl_n;
	logic [8:0] count_n;
	logic       submit;
	logic       tracked;
	logic [8:0] after;
	logic [8:0] udl_pos;

	always_comb begin
		head_n   = (count_q == 9'd0) ? data_byte : head_q;
		submit   = head_n[1:0] == stpc_pkg::MT_SUBMIT;
		// only submit and deliver have fields past the first byte
		tracked  = (count_q != 9'd0) && !head_n[1];
		digits_n = digits_q;
		if (tracked && count_q == (submit ? 9'd2 : 9'd1))
			digits_n = data_byte;
		after    = stpc_pkg::after_address(submit, digits_n);
		dcs_n    = dcs_q;
		if (tracked && count_q == after + 9'd1)
			dcs_n = data_byte;
		udl_pos  = after + 9'd2 + {5'd0, stpc_pkg::vp_bytes(submit, head_n)};
		udl_n    = udl_q;
		if (tracked && count_q == udl_pos)
			udl_n = data_byte;
		count_n  = (count_q != stpc_pkg::COUNT_MAX) ? count_q + 9'd1 : count_q;
	end

	assign snap = '{head: head_n, digits: digits_n, dcs: dcs_n, udl: udl_n,
		len: count_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= 9'd0;
			head_q   <= 8'd0;
			digits_q <= 8'd0;
			dcs_q    <= 8'd0;
			udl_q    <= 8'd0;
		end else if (take) begin
			if (last) begin
				count_q  <= 9'd0;
				head_q   <= 8'd0;
				digits_q <= 8'd0;
				dcs_q    <= 8'd0;
				udl_q    <= 8'd0;
			end else begin
				count_q  <= count_n;
				head_q   <= head_n;
				digits_q <= digits_n;
				dcs_q    <= dcs_n;
				udl_q    <= udl_n;
			end
		end
	end

endmodule

### rtl/stpc_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpc_check
// layout checks of one finished tpdu, first failure wins
// ----------------------------------------------------------------------------
module stpc_check (
	input  stpc_pkg::frame_t frame,
	input  logic [7:0]       max_length,
	output logic [2:0]       status
);

	logic [9:0]  len;
	logic        submit;
	logic [9:0]  after;
	logic [9:0]  pos_vp;
	logic [9:0]  pos_udl;
	logic [3:0]  vb;
	logic [10:0] septet_bytes;
	logic [7:0]  octets;
	logic [9:0]  ud_end;

	always_comb begin
		len          = {1'b0, frame.len};
		submit       = frame.head[1:0] == stpc_pkg::MT_SUBMIT;
		after        = {1'b0, stpc_pkg::after_address(submit, frame.digits)};
		pos_vp       = after + 10'd2;
		vb           = stpc_pkg::vp_bytes(submit, frame.head);
		pos_udl      = pos_vp + {6'd0, vb};
		// septets to bytes: (udl*7 + 7) / 8
		septet_bytes = ({3'd0, frame.udl} << 3) - {3'd0, frame.udl} + 11'd7;
		octets       = stpc_pkg::dcs_is_gsm7(frame.dcs) ? septet_bytes[10:3] : frame.udl;
		ud_end       = pos_udl + 10'd1 + {2'd0, octets};

		if (len > {2'd0, max_length})
			status = stpc_pkg::ST_TOO_LONG;
		else if (frame.head[1])
			status = (len < 10'd2) ? stpc_pkg::ST_TOO_SHORT : stpc_pkg::ST_OK;
		else if (len < (submit ? 10'd4 : 10'd3))
			status = stpc_pkg::ST_TOO_SHORT;
		else if (after > len)
			status = stpc_pkg::ST_ADDR_TRUNC;
		else if (pos_vp > len)
			status = stpc_pkg::ST_NO_PID_DCS;
		else if (submit && vb != 4'd0 && pos_udl > len)
			status = stpc_pkg::ST_NO_VP;
		else if (!submit && pos_udl > len)
			status = stpc_pkg::ST_NO_STAMP;
		else if (pos_udl >= len)
			status = stpc_pkg::ST_OK;
		else if (ud_end > len)
			status = stpc_pkg::ST_UD_TRUNC;
		else
			status = stpc_pkg::ST_OK;
	end

endmodule

### rtl/sms_tpdu_structure_check_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sms_tpdu_structure_check_top
// streaming structure check of sms tpdus with one report per tpdu
// ----------------------------------------------------------------------------
// The block takes a TPDU one byte per beat on the tpdu channel, last marking
// the final byte, and sends one report beat per TPDU on the report channel:
// status, message type, first octet and byte count (saturating at 511). A
// byte is taken in every cycle with tpdu ready high; the byte counter and the field
// captures (address digit count, DCS, UDL at positions the earlier bytes imply)
// update in the accepting cycle. The final byte copies the TPDU's fields into a
// snapshot stage, the checks run from that snapshot into the report register,
// which loads from the snapshot once it is empty or its report is taken, and
// the report is offered while it holds one. Snapshot and report register each
// hold one TPDU, so the byte stream only stalls when both are full and the
// report is not taken. max_length (APB, byte address 0, reset 164) is read
// during the check; write it only while no TPDU is in flight.
// ----------------------------------------------------------------------------
module sms_tpdu_structure_check_top (
	input  logic                 clk,
	input  logic                 arst_n,
	stpc_byte_if.sink            tpdu,
	stpc_result_if.source        report,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// configuration
	logic [7:0] max_length_q;
	logic       reg_sel;

	// frame tracking
	logic              take;
	stpc_pkg::frame_t  snap;

	// snapshot stage
	logic              s1_valid_q;
	stpc_pkg::frame_t  frame_s1;

	// report register
	logic       out_valid_q;
	logic       out_free;
	logic [2:0] status_q;
	logic [7:0] lead_byte_q;
	logic [8:0] total_length_q;
	logic [2:0] status_c;

	// apb register, word index in paddr[2]
	assign pready  = 1'b1;
	assign reg_sel = paddr[2] == stpc_pkg::REG_MAX_LENGTH;
	assign prdata  = reg_sel ? {24'd0, max_length_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= stpc_pkg::MAX_LENGTH_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			max_length_q <= pwdata[7:0];
		end
	end

	// handshakes: report register drains first, then the snapshot moves up
	assign out_free   = !out_valid_q || report.ready;
	assign tpdu.ready = !s1_valid_q || out_free;
	assign take       = tpdu.valid && tpdu.ready;

	stpc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (tpdu.data_byte),
		.last      (tpdu.last),
		.snap      (snap)
	);

	// snapshot of a finished tpdu
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take && tpdu.last) begin
			s1_valid_q <= 1'b1;
		end else if (out_free) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && tpdu.last) begin
			frame_s1 <= snap;
		end
	end

	stpc_check u_check (
		.frame      (frame_s1),
		.max_length (max_length_q),
		.status     (status_c)
	);

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_valid_q) begin
			status_q       <= status_c;
			lead_byte_q    <= frame_s1.head;
			total_length_q <= frame_s1.len;
		end
	end

	assign report.valid        = out_valid_q;
	assign report.status       = status_q;
	assign report.message_type = lead_byte_q[1:0];
	assign report.lead_byte    = lead_byte_q;
	assign report.total_length = total_length_q;

`ifndef SYNTHESIS
	// a final byte always lands in the snapshot stage
	a_last_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		take && tpdu.last |=> s1_valid_q)
		else $error("final byte not captured in snapshot stage");

	// both stages full and stalled: no byte may be taken
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && out_valid_q && !report.ready |-> !tpdu.ready)
		else $error("byte accepted with both stages full");

	// a reported tpdu has at least one byte
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid |-> report.total_length != 9'd0)
		else $error("report with zero length");

	// report and command tpdus only see the length checks
	a_short_types: assert property (@(posedge clk) disable iff (!arst_n)
		report.valid && report.message_type[1] |->
			report.status == stpc_pkg::ST_OK ||
			report.status == stpc_pkg::ST_TOO_LONG ||
			report.status == stpc_pkg::ST_TOO_SHORT)
		else $error("layout status on a report or command tpdu");
`endif

endmodule
